/* hw/rtl/key_value_table_macros.svh */
// Assertion macros shared by the key/value table RTL.
`ifndef KEY_VALUE_TABLE_MACROS_SVH
`define KEY_VALUE_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define KVT_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("key_value_table assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define KVT_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("key_value_table assertion failed");

`endif

/* hw/rtl/kvt_pkg.sv */
// Types and constants for the key/value table.
package kvt_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int KEY_BITS      = 32;
    localparam int VALUE_BITS    = 32;

    // Field widths on the ports
    localparam int FUNC_W   = 2;
    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int HELD_W   = 5;
    localparam int S_DATA_W = 64;
    localparam int M_DATA_W = 40;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [FUNC_W-1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_LOOKUP = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_CHANGE = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_DUPLICATE = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE
    } state_t;

    typedef struct packed {
        logic                  done;
        logic                  hit;
        logic [IDX_W-1:0]      hit_idx;
        logic [VALUE_BITS-1:0] hit_value;
        logic                  free_found;
        logic [IDX_W-1:0]      free_idx;
    } scan_result_t;

endpackage

/* hw/rtl/key_value_table.sv */
// Associative key/value table with unique keys: insert, lookup, remove and change value.
// The scan ends at the slot that matches the key, or after the last slot when the key is
// absent. The key is compared against one table entry per cycle through the single read
// port of the key and value RAMs, then the S_UPDATE state applies the update. One request
// is in flight at a time, and s_tready rises in the same cycle as the result appears in
// the output register. The result sits in an output register, so the next request is
// taken as soon as the update is done, even if the result has not yet been taken; that
// request's update then waits for the output register. Valid marks and the entry count
// clear at reset; key and value storage needs no clearing.
`include "key_value_table_macros.svh"

module key_value_table
    import kvt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // key[31:0], value_in[63:32]
    input  logic [FUNC_W-1:0]   s_tuser,   // func[1:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata    // found[0], value_out[32:1], status[34:33],
                                           // entries_held[39:35]
);

    state_t                   state_reg, state_next;
    func_t                    func_reg;
    logic [KEY_BITS-1:0]      key_reg;
    logic [VALUE_BITS-1:0]    value_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg, valid_next;
    logic [CNT_W-1:0]         count_reg, count_next;

    logic                     m_tvalid_reg, m_tvalid_next;
    logic                     found_reg, found_next;
    logic [VALUE_W-1:0]       value_out_reg, value_out_next;
    status_t                  status_reg, status_next;
    logic [HELD_W-1:0]        held_reg, held_next;

    logic                     in_fire;
    logic                     scan_start;
    logic                     advance;
    logic                     table_full;
    scan_result_t             scan_res;
    logic [IDX_W-1:0]         rd_addr;
    logic [KEY_BITS-1:0]      key_rdata;
    logic [VALUE_BITS-1:0]    value_rdata;
    logic                     key_we;
    logic                     value_we;
    logic [IDX_W-1:0]         wr_addr;

    assign s_tready = (state_reg == S_IDLE);
    assign in_fire  = s_tvalid && s_tready;
    // update may only proceed once the output register is free
    assign advance    = (state_reg == S_UPDATE) && (!m_tvalid_reg || m_tready);
    assign table_full = (count_reg >= CNT_W'(TABLE_ENTRIES));

    kvt_scan u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (scan_start),
        .key         (key_reg),
        .valid       (valid_reg),
        .rd_addr     (rd_addr),
        .key_rdata   (key_rdata),
        .value_rdata (value_rdata),
        .result      (scan_res)
    );

    kvt_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (TABLE_ENTRIES)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (wr_addr),
        .wdata (key_reg),
        .raddr (rd_addr),
        .rdata (key_rdata)
    );

    kvt_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (TABLE_ENTRIES)
    ) u_value_ram (
        .clk   (clk),
        .we    (value_we),
        .waddr (wr_addr),
        .wdata (value_reg),
        .raddr (rd_addr),
        .rdata (value_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        scan_start     = 1'b0;
        valid_next     = valid_reg;
        count_next     = count_reg;
        key_we         = 1'b0;
        value_we       = 1'b0;
        wr_addr        = scan_res.hit_idx;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        found_next     = found_reg;
        value_out_next = value_out_reg;
        status_next    = status_reg;
        held_next      = held_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    scan_start = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (scan_res.done)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                if (advance)
                begin
                    found_next     = scan_res.hit;
                    value_out_next = '0;
                    status_next    = ST_DONE;
                    case (func_reg)
                        FUNC_INSERT:
                        begin
                            if (scan_res.hit)
                            begin
                                status_next = ST_DUPLICATE;
                            end
                            else if (table_full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                wr_addr                      = scan_res.free_idx;
                                key_we                       = 1'b1;
                                value_we                     = 1'b1;
                                valid_next[scan_res.free_idx] = 1'b1;
                                count_next                   = count_reg + CNT_W'(1);
                            end
                        end
                        FUNC_LOOKUP:
                        begin
                            if (scan_res.hit)
                            begin
                                value_out_next = VALUE_W'(scan_res.hit_value);
                            end
                            else
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                        end
                        FUNC_REMOVE:
                        begin
                            if (scan_res.hit)
                            begin
                                valid_next[scan_res.hit_idx] = 1'b0;
                                count_next                   = count_reg - CNT_W'(1);
                            end
                            else
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                        end
                        FUNC_CHANGE:
                        begin
                            if (scan_res.hit)
                            begin
                                value_we = 1'b1;
                            end
                            else
                            begin
                                status_next = ST_NOT_FOUND;
                            end
                        end
                        default:
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                    endcase
                    held_next     = HELD_W'(count_next);
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            valid_reg    <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            func_reg  <= func_t'(s_tuser);
            key_reg   <= s_tdata[KEY_BITS-1:0];
            value_reg <= s_tdata[KEY_W +: VALUE_BITS];
        end
        found_reg     <= found_next;
        value_out_reg <= value_out_next;
        status_reg    <= status_next;
        held_reg      <= held_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {held_reg, status_reg, value_out_reg, found_reg};

    // entry count always matches the valid marks
    `KVT_ASSERT_IMPLY(a_count_matches_valid, clk, rst_n, 1'b1,
        $countones(valid_reg) == 32'(count_reg))
    // a hit waiting to be applied always points at a live entry
    `KVT_ASSERT_IMPLY(a_hit_is_valid, clk, rst_n, (state_reg == S_UPDATE) && scan_res.hit,
        valid_reg[scan_res.hit_idx])
    // a successful insert raises the count by one
    `KVT_ASSERT_NEXT(a_insert_counts, clk, rst_n,
        advance && (func_reg == FUNC_INSERT) && !scan_res.hit && !table_full,
        count_reg == $past(count_reg) + CNT_W'(1))

endmodule

/* hw/rtl/kvt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module kvt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/kvt_scan.sv */
// Key scan unit: walks the table one entry per cycle through the RAM read port.
module kvt_scan
    import kvt_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [KEY_BITS-1:0]      key,
    input  logic [TABLE_ENTRIES-1:0] valid,
    output logic [IDX_W-1:0]         rd_addr,
    input  logic [KEY_BITS-1:0]      key_rdata,
    input  logic [VALUE_BITS-1:0]    value_rdata,
    output scan_result_t             result
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

    logic                  active_reg, active_next;
    logic [IDX_W-1:0]      issue_idx_reg, issue_idx_next;
    logic                  cmp_vld_reg, cmp_vld_next;
    logic [IDX_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic                  done_reg, done_next;
    logic                  hit_reg, hit_next;
    logic [IDX_W-1:0]      hit_idx_reg, hit_idx_next;
    logic [VALUE_BITS-1:0] hit_value_reg, hit_value_next;
    logic                  free_found_reg, free_found_next;
    logic [IDX_W-1:0]      free_idx_reg, free_idx_next;
    logic                  match;

    assign rd_addr = issue_idx_reg;
    assign match   = cmp_vld_reg && valid[cmp_idx_reg] && (key_rdata == key);

    always_comb
    begin
        active_next     = active_reg;
        issue_idx_next  = issue_idx_reg;
        cmp_vld_next    = cmp_vld_reg;
        cmp_idx_next    = cmp_idx_reg;
        done_next       = done_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_value_next  = hit_value_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;

        if (start)
        begin
            active_next     = 1'b1;
            issue_idx_next  = '0;
            cmp_vld_next    = 1'b0;
            done_next       = 1'b0;
            hit_next        = 1'b0;
            free_found_next = 1'b0;
        end
        else
        begin
            // read data arrives in the cycle after its address is issued
            cmp_vld_next = active_reg;
            if (active_reg)
            begin
                cmp_idx_next = issue_idx_reg;
                if (issue_idx_reg == LAST_IDX)
                begin
                    active_next = 1'b0;
                end
                else
                begin
                    issue_idx_next = issue_idx_reg + IDX_W'(1);
                end
            end

            if (cmp_vld_reg)
            begin
                // lowest free slot, for inserts
                if (!valid[cmp_idx_reg] && !free_found_reg)
                begin
                    free_found_next = 1'b1;
                    free_idx_next   = cmp_idx_reg;
                end
                if (match)
                begin
                    hit_next       = 1'b1;
                    hit_idx_next   = cmp_idx_reg;
                    hit_value_next = value_rdata;
                    done_next      = 1'b1;
                    active_next    = 1'b0;
                    cmp_vld_next   = 1'b0;
                end
                else if (cmp_idx_reg == LAST_IDX)
                begin
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            cmp_vld_reg    <= 1'b0;
            done_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            active_reg     <= active_next;
            cmp_vld_reg    <= cmp_vld_next;
            done_reg       <= done_next;
            hit_reg        <= hit_next;
            free_found_reg <= free_found_next;
        end
    end

    always_ff @(posedge clk)
    begin
        issue_idx_reg <= issue_idx_next;
        cmp_idx_reg   <= cmp_idx_next;
        hit_idx_reg   <= hit_idx_next;
        hit_value_reg <= hit_value_next;
        free_idx_reg  <= free_idx_next;
    end

    assign result.done       = done_reg;
    assign result.hit        = hit_reg;
    assign result.hit_idx    = hit_idx_reg;
    assign result.hit_value  = hit_value_reg;
    assign result.free_found = free_found_reg;
    assign result.free_idx   = free_idx_reg;

endmodule
